/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define AMI_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled during reset
`define AMI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/ami_pkg.sv */
// ----------------------------------------------------------------------------
// ami_pkg
// Widths, row codes and shared types of the affine matrix inverse unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ami_pkg;

	localparam int EW    = 32;        // element width, Q16.16
	localparam int FRAC  = 16;        // fraction bits
	localparam int CW    = 65;        // cofactor width, signed
	localparam int PW    = 97;        // determinant / translation numerator width
	localparam int NW    = 114;       // rounded dividend width
	localparam int DW    = 97;        // divisor width (twice |det|)
	localparam int RW    = 98;        // partial remainder width
	localparam int QW    = 32;        // quotient bits
	localparam int HW    = NW - QW;   // dividend bits above the quotient window
	localparam int NLANE = 4;         // three linear columns and translation

	localparam logic [1:0] ROW_FIRST = 2'd0;
	localparam logic [1:0] ROW_LAST  = 2'd2;

	typedef struct packed {
		logic          big;
		logic [QW-1:0] q;
	} div_res_t;

	typedef struct packed {
		logic             vld;
		logic [1:0]       row;
		logic [NLANE-1:0] neg;
		logic             sing;
	} side_t;

endpackage

`default_nettype wire

/* rtl/ami_div_lane.sv */
// ----------------------------------------------------------------------------
// ami_div_lane
// Pipelined restoring divider: a setup stage, then one quotient bit per stage, QW+1 stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ami_div_lane import ami_pkg::*; (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [NW-1:0] n,
	input  wire logic [DW-1:0] d,
	output div_res_t           res
);

	logic [RW-1:0] rem_q [QW+1];
	logic [QW-1:0] nlo_q [QW+1];
	logic [DW-1:0] dd_q  [QW+1];
	logic [QW-1:0] q_q   [QW+1];
	logic          big_q [QW+1];

	// quotient overflows 32 bits when the upper dividend bits reach the divisor
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= {{(RW-HW){1'b0}}, n[NW-1:QW]};
			nlo_q[0] <= n[QW-1:0];
			dd_q[0]  <= d;
			q_q[0]   <= '0;
			big_q[0] <= {{(DW-HW){1'b0}}, n[NW-1:QW]} >= d;
		end
	end

	for (genvar j = 1; j <= QW; j++) begin : g_step
		logic [RW-1:0] trial;
		logic [RW-1:0] dext;
		logic          ge;

		always_comb begin
			trial = {rem_q[j-1][RW-2:0], nlo_q[j-1][QW-1]};
			dext  = {1'b0, dd_q[j-1]};
			ge    = trial >= dext;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[j] <= ge ? (trial - dext) : trial;
				nlo_q[j] <= {nlo_q[j-1][QW-2:0], 1'b0};
				dd_q[j]  <= dd_q[j-1];
				q_q[j]   <= {q_q[j-1][QW-2:0], ge};
				big_q[j] <= big_q[j-1];
			end
		end
	end

	assign res = '{big: big_q[QW], q: q_q[QW]};

endmodule

`default_nettype wire

/* rtl/affine_matrix_inverse_unit.sv */
// ----------------------------------------------------------------------------
// affine_matrix_inverse_unit
// Inverse of a 3x4 affine transform in Q16.16, returned one row per word.
// ----------------------------------------------------------------------------
// One transform word in gives three row words out, rows 0, 1, 2 on
// consecutive cycles when the sink is ready; a new transform is taken in the
// cycle that issues the last row of the one before, as the single result
// channel delivers one row per cycle. Each row passes seven arithmetic stages
// (products, cofactors, split wide products, wide products, sums, magnitudes,
// dividend setup), a 33-stage restoring divider (a setup stage, then one
// quotient bit per stage), then an output register. Every element is rounded
// to nearest (ties away from zero) and saturated; a zero determinant gives
// zero rows with singular set.
// ----------------------------------------------------------------------------
`default_nettype none

module affine_matrix_inverse_unit import ami_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic signed [EW-1:0] src_r0_c0,
	input  wire logic signed [EW-1:0] src_r0_c1,
	input  wire logic signed [EW-1:0] src_r0_c2,
	input  wire logic signed [EW-1:0] src_r0_c3,
	input  wire logic signed [EW-1:0] src_r1_c0,
	input  wire logic signed [EW-1:0] src_r1_c1,
	input  wire logic signed [EW-1:0] src_r1_c2,
	input  wire logic signed [EW-1:0] src_r1_c3,
	input  wire logic signed [EW-1:0] src_r2_c0,
	input  wire logic signed [EW-1:0] src_r2_c1,
	input  wire logic signed [EW-1:0] src_r2_c2,
	input  wire logic signed [EW-1:0] src_r2_c3,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [1:0]                row_index,
	output logic signed [EW-1:0]      inv_c0,
	output logic signed [EW-1:0]      inv_c1,
	output logic signed [EW-1:0]      inv_c2,
	output logic signed [EW-1:0]      inv_c3,
	output logic                      singular,
	output logic                      last_row
);

	// ---------------- input hold and row issue ----------------
	logic                 hold_vld_q;
	logic [1:0]           row_q;
	logic signed [EW-1:0] a_q [3][4];
	logic                 adv;
	logic                 accept;
	logic                 issue;

	assign adv      = !out_valid || out_ready;
	assign in_ready = !hold_vld_q || (adv && row_q == ROW_LAST);
	assign accept   = in_valid && in_ready;
	assign issue    = hold_vld_q && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_vld_q <= 1'b0;
			row_q      <= ROW_FIRST;
		end else if (accept) begin
			hold_vld_q <= 1'b1;
			row_q      <= ROW_FIRST;
		end else if (issue) begin
			if (row_q == ROW_LAST) begin
				hold_vld_q <= 1'b0;
				row_q      <= ROW_FIRST;
			end else begin
				row_q <= row_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			a_q[0][0] <= src_r0_c0; a_q[0][1] <= src_r0_c1;
			a_q[0][2] <= src_r0_c2; a_q[0][3] <= src_r0_c3;
			a_q[1][0] <= src_r1_c0; a_q[1][1] <= src_r1_c1;
			a_q[1][2] <= src_r1_c2; a_q[1][3] <= src_r1_c3;
			a_q[2][0] <= src_r2_c0; a_q[2][1] <= src_r2_c1;
			a_q[2][2] <= src_r2_c2; a_q[2][3] <= src_r2_c3;
		end
	end

	// operand pairs: entries 0..2 are the adjugate cofactors of the issued row,
	// 3..5 the first-row cofactors that build the determinant
	logic signed [EW-1:0] op [6][4];

	always_comb begin
		case (row_q)
			ROW_FIRST: begin
				op[0] = '{a_q[1][1], a_q[2][2], a_q[1][2], a_q[2][1]};
				op[1] = '{a_q[0][2], a_q[2][1], a_q[0][1], a_q[2][2]};
				op[2] = '{a_q[0][1], a_q[1][2], a_q[0][2], a_q[1][1]};
			end
			ROW_LAST: begin
				op[0] = '{a_q[1][0], a_q[2][1], a_q[1][1], a_q[2][0]};
				op[1] = '{a_q[0][1], a_q[2][0], a_q[0][0], a_q[2][1]};
				op[2] = '{a_q[0][0], a_q[1][1], a_q[0][1], a_q[1][0]};
			end
			default: begin
				op[0] = '{a_q[1][2], a_q[2][0], a_q[1][0], a_q[2][2]};
				op[1] = '{a_q[0][0], a_q[2][2], a_q[0][2], a_q[2][0]};
				op[2] = '{a_q[0][2], a_q[1][0], a_q[0][0], a_q[1][2]};
			end
		endcase
		op[3] = '{a_q[1][1], a_q[2][2], a_q[1][2], a_q[2][1]};
		op[4] = '{a_q[1][2], a_q[2][0], a_q[1][0], a_q[2][2]};
		op[5] = '{a_q[1][0], a_q[2][1], a_q[1][1], a_q[2][0]};
	end

	// ---------------- S1: element products ----------------
	logic                   vld_s1;
	logic [1:0]             row_s1;
	logic signed [2*EW-1:0] p_s1  [6][2];
	logic signed [EW-1:0]   a0_s1 [3];
	logic signed [EW-1:0]   b_s1  [3];

	// ---------------- S2: cofactors ----------------
	logic                 vld_s2;
	logic [1:0]           row_s2;
	logic signed [CW-1:0] crow_s2 [3];
	logic signed [CW-1:0] ccol_s2 [3];
	logic signed [EW-1:0] a0_s2   [3];
	logic signed [EW-1:0] b_s2    [3];

	// ---------------- S3: partial wide products ----------------
	logic                 vld_s3;
	logic [1:0]           row_s3;
	logic signed [CW-1:0] dlo_s3  [3];
	logic signed [CW-1:0] dhi_s3  [3];
	logic signed [CW-1:0] tlo_s3  [3];
	logic signed [CW-1:0] thi_s3  [3];
	logic signed [CW-1:0] crow_s3 [3];

	// ---------------- S4: wide products ----------------
	logic                 vld_s4;
	logic [1:0]           row_s4;
	logic [PW-1:0]        dp_s4   [3];
	logic [PW-1:0]        tp_s4   [3];
	logic signed [CW-1:0] crow_s4 [3];

	// ---------------- S5: determinant and translation numerator ----------------
	logic                 vld_s5;
	logic [1:0]           row_s5;
	logic [PW-1:0]        det_s5;
	logic [PW-1:0]        tnum_s5;
	logic signed [CW-1:0] crow_s5 [3];

	// ---------------- S6: magnitudes and signs ----------------
	logic             vld_s6;
	logic [1:0]       row_s6;
	logic [PW-2:0]    dabs_s6;
	logic [PW-2:0]    tabs_s6;
	logic [CW-2:0]    cabs_s6 [3];
	logic [NLANE-1:0] neg_s6;
	logic             sing_s6;

	// ---------------- S7: dividend and divisor ----------------
	logic             vld_s7;
	logic [1:0]       row_s7;
	logic [NW-1:0]    n_s7 [NLANE];
	logic [DW-1:0]    d_s7;
	logic [NLANE-1:0] neg_s7;
	logic             sing_s7;

	logic [PW-1:0] det_c;
	logic [PW-1:0] tnum_c;
	logic [CW-1:0] cof_c [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0; vld_s4 <= 1'b0;
			vld_s5 <= 1'b0; vld_s6 <= 1'b0; vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= hold_vld_q;
			vld_s2 <= vld_s1; vld_s3 <= vld_s2; vld_s4 <= vld_s3;
			vld_s5 <= vld_s4; vld_s6 <= vld_s5; vld_s7 <= vld_s6;
		end
	end

	always_comb begin
		det_c  = det_s5[PW-1]  ? (PW'(0) - det_s5)  : det_s5;
		tnum_c = tnum_s5[PW-1] ? (PW'(0) - tnum_s5) : tnum_s5;
		for (int i = 0; i < 3; i++) begin
			cof_c[i] = crow_s5[i][CW-1] ? (CW'(0) - crow_s5[i]) : crow_s5[i];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			row_s1 <= row_q;
			for (int i = 0; i < 6; i++) begin
				p_s1[i][0] <= op[i][0] * op[i][1];
				p_s1[i][1] <= op[i][2] * op[i][3];
			end
			for (int i = 0; i < 3; i++) begin
				a0_s1[i] <= a_q[0][i];
				b_s1[i]  <= a_q[i][3];
			end

			row_s2 <= row_s1;
			for (int i = 0; i < 3; i++) begin
				crow_s2[i] <= {p_s1[i][0][2*EW-1], p_s1[i][0]}
				            - {p_s1[i][1][2*EW-1], p_s1[i][1]};
				ccol_s2[i] <= {p_s1[i+3][0][2*EW-1], p_s1[i+3][0]}
				            - {p_s1[i+3][1][2*EW-1], p_s1[i+3][1]};
				a0_s2[i] <= a0_s1[i];
				b_s2[i]  <= b_s1[i];
			end

			// cofactor times element, split at bit 32 of the cofactor
			row_s3 <= row_s2;
			for (int i = 0; i < 3; i++) begin
				dlo_s3[i]  <= $signed({1'b0, ccol_s2[i][EW-1:0]}) * a0_s2[i];
				dhi_s3[i]  <= $signed(ccol_s2[i][CW-1:EW]) * a0_s2[i];
				tlo_s3[i]  <= $signed({1'b0, crow_s2[i][EW-1:0]}) * b_s2[i];
				thi_s3[i]  <= $signed(crow_s2[i][CW-1:EW]) * b_s2[i];
				crow_s3[i] <= crow_s2[i];
			end

			row_s4 <= row_s3;
			for (int i = 0; i < 3; i++) begin
				dp_s4[i]   <= {dhi_s3[i], {EW{1'b0}}} + {{EW{dlo_s3[i][CW-1]}}, dlo_s3[i]};
				tp_s4[i]   <= {thi_s3[i], {EW{1'b0}}} + {{EW{tlo_s3[i][CW-1]}}, tlo_s3[i]};
				crow_s4[i] <= crow_s3[i];
			end

			row_s5  <= row_s4;
			det_s5  <= dp_s4[0] + dp_s4[1] + dp_s4[2];
			tnum_s5 <= PW'(0) - (tp_s4[0] + tp_s4[1] + tp_s4[2]);
			for (int i = 0; i < 3; i++) begin
				crow_s5[i] <= crow_s4[i];
			end

			row_s6  <= row_s5;
			dabs_s6 <= det_c[PW-2:0];
			tabs_s6 <= tnum_c[PW-2:0];
			for (int i = 0; i < 3; i++) begin
				cabs_s6[i] <= cof_c[i][CW-2:0];
				neg_s6[i]  <= crow_s5[i][CW-1] ^ det_s5[PW-1];
			end
			neg_s6[NLANE-1] <= tnum_s5[PW-1] ^ det_s5[PW-1];
			sing_s6         <= det_s5 == '0;

			// dividend 2n + |det| against divisor 2|det| gives round to nearest
			row_s7 <= row_s6;
			for (int i = 0; i < 3; i++) begin
				n_s7[i] <= NW'({cabs_s6[i], {(2*FRAC+1){1'b0}}}) + NW'(dabs_s6);
			end
			n_s7[NLANE-1] <= NW'({tabs_s6, {(FRAC+1){1'b0}}}) + NW'(dabs_s6);
			d_s7    <= {dabs_s6, 1'b0};
			neg_s7  <= neg_s6;
			sing_s7 <= sing_s6;
		end
	end

	// ---------------- divider lanes ----------------
	div_res_t res [NLANE];

	for (genvar l = 0; l < NLANE; l++) begin : g_lane
		ami_div_lane u_div (
			.clk (clk),
			.en  (adv),
			.n   (n_s7[l]),
			.d   (d_s7),
			.res (res[l])
		);
	end

	side_t side_dly_q [QW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QW; k++) begin
				side_dly_q[k] <= '0;
			end
		end else if (adv) begin
			side_dly_q[0] <= '{vld: vld_s7, row: row_s7, neg: neg_s7, sing: sing_s7};
			for (int k = 1; k <= QW; k++) begin
				side_dly_q[k] <= side_dly_q[k-1];
			end
		end
	end

	// ---------------- saturation and output word ----------------
	function automatic logic [EW-1:0] round_sat(div_res_t r, logic neg, logic sing);
		logic [EW-1:0] lim;
		logic [EW-1:0] mag;
		lim = neg ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
		mag = (r.big || r.q > lim) ? lim : r.q;
		if (sing) begin
			return '0;
		end
		return neg ? (EW'(0) - mag) : mag;
	endfunction

	side_t         side_end;
	logic          out_vld_q;
	logic [1:0]    row_out_q;
	logic [EW-1:0] inv_q [NLANE];
	logic          sing_q;

	assign side_end = side_dly_q[QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= side_end.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			row_out_q <= side_end.row;
			sing_q    <= side_end.sing;
			for (int l = 0; l < NLANE; l++) begin
				inv_q[l] <= round_sat(res[l], side_end.neg[l], side_end.sing);
			end
		end
	end

	assign out_valid = out_vld_q;
	assign row_index = row_out_q;
	assign inv_c0    = inv_q[0];
	assign inv_c1    = inv_q[1];
	assign inv_c2    = inv_q[2];
	assign inv_c3    = inv_q[3];
	assign singular  = sing_q;
	assign last_row  = row_out_q == ROW_LAST;

endmodule

`default_nettype wire

/* rtl/ami_checker.sv */
// ----------------------------------------------------------------------------
// ami_checker
// Port-level checks on the row words of the affine matrix inverse unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ami_checker import ami_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire logic [1:0]           row_index,
	input wire logic signed [EW-1:0] inv_c0,
	input wire logic signed [EW-1:0] inv_c1,
	input wire logic signed [EW-1:0] inv_c2,
	input wire logic signed [EW-1:0] inv_c3,
	input wire logic                 singular,
	input wire logic                 last_row
);

	logic                       out_fire;
	logic                       out_stall;
	logic                       inv_zero;
	logic [2+4*EW+2-1:0]        out_word;

	assign out_fire  = out_valid && out_ready;
	assign out_stall = out_valid && !out_ready;
	assign inv_zero  = inv_c0 == '0 && inv_c1 == '0 && inv_c2 == '0 && inv_c3 == '0;
	assign out_word  = {row_index, inv_c0, inv_c1, inv_c2, inv_c3, singular, last_row};

	// stalled word holds
	`AMI_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, out_valid && $stable(out_word))

	// singular transform gives all-zero rows
	`AMI_ASSERT_NOW(a_sing_zero, clk, arst_n, out_valid && singular, inv_zero)

	// rows of one transform follow back to back with one singular flag
	`AMI_ASSERT_NEXT(a_row_seq, clk, arst_n, out_fire && !last_row, out_valid && row_index == $past(row_index) + 2'd1 && singular == $past(singular))

	// a transform's words start at the first row after its last row
	`AMI_ASSERT_NEXT(a_row_wrap, clk, arst_n, out_fire && last_row, !out_valid || row_index == ROW_FIRST)

endmodule

bind affine_matrix_inverse_unit ami_checker u_ami_checker (.*);

`default_nettype wire
